// File: hdl/lcpf_pkg.sv
// Package for the LRU cache with pending fills.
// Holds parameter defaults, field widths, operation codes and status codes; no dependencies.
package lcpf_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned PendingDef = 8;

  localparam int unsigned CapW = 5;
  localparam int unsigned CntW = 48;

  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpFill   = 2'd1;
  localparam logic [1:0] OpClear  = 2'd2;

  localparam logic [2:0] StHit       = 3'd0;
  localparam logic [2:0] StCompile   = 3'd1;
  localparam logic [2:0] StWait      = 3'd2;
  localparam logic [2:0] StUncached  = 3'd3;
  localparam logic [2:0] StStored    = 3'd4;
  localparam logic [2:0] StDiscarded = 3'd5;
  localparam logic [2:0] StCleared   = 3'd6;
  localparam logic [2:0] StPendFull  = 3'd7;

endpackage

// File: hdl/lru_cache_with_pending_fills.sv
// Fully associative LRU cache of key-to-handle entries with pending-fill tracking.
// Depends on lcpf_pkg (defaults, operation and status codes).
//
// Usage:
//   Requests enter on the s_axis channel (tuser = opcode, tdata = key, handle,
//   fill_ok, fill epoch). One result per request leaves on m_axis (tuser =
//   status, tdata = handle, epoch, entry count and five 48-bit counters).
//   capacity is written through cfg_we_i / cfg_wdata_i; the user must write it only while
//   the block is idle, which the block itself does not enforce; values above ENTRIES saturate to ENTRIES.
// Timing:
//   A lookup or fill completion walks the entry and pending tables with one
//   shared key comparator per table, one index per cycle, over max(ENTRIES,
//   PENDING_SLOTS) indices; a decide state and an output state follow the scan.
//   Clear, opcode three and capacity-zero lookups skip the scan and go straight
//   from accept to the decide state.
//   One request is in flight at a time; s_axis_tready is high only when idle.
// Reset:
//   All entries and pending slots invalid, epoch and counters zero,
//   capacity = min(16, ENTRIES). No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; a new request may be
//   accepted meanwhile and its result is held back until the register frees.
module lru_cache_with_pending_fills #(
  parameter int unsigned ENTRIES       = lcpf_pkg::EntriesDef,
  parameter int unsigned PENDING_SLOTS = lcpf_pkg::PendingDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,     // capacity
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,    // key[63:0] handle[95:64] fill_ok[96] fill_epoch[128:97]
  input  logic [1:0]   s_axis_tuser,    // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [311:0] m_axis_tdata,    // plan[31:0] epoch[63:32] count[68:64] hit[116:69]
                                        // miss[164:117] compile[212:165] wait[260:213]
                                        // evict[308:261]
  output logic [2:0]   m_axis_tuser     // status
);
  import lcpf_pkg::*;

  localparam int unsigned Scan = (ENTRIES > PENDING_SLOTS) ? ENTRIES : PENDING_SLOTS;
  localparam int unsigned EiW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PiW  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int unsigned SiW  = (Scan > 1) ? $clog2(Scan) : 1;
  localparam int unsigned IdxW = (SiW > EiW) ? ((SiW > PiW) ? SiW : PiW)
                                             : ((EiW > PiW) ? EiW : PiW);
  localparam int unsigned RkW  = EiW;
  localparam int unsigned NW   = $clog2(ENTRIES + 1);
  localparam int unsigned WideW = 10; // holds counts up to 256 and capacity
  localparam logic [CapW-1:0] CapRst = (ENTRIES < 16) ? CapW'(ENTRIES) : CapW'(16);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // table storage
  logic [63:0]    ekey_q [ENTRIES];
  logic [31:0]    ehdl_q [ENTRIES];
  logic           evld_q [ENTRIES];
  logic [RkW-1:0] erank_q[ENTRIES];
  logic [63:0]    pkey_q [PENDING_SLOTS];
  logic [31:0]    pep_q  [PENDING_SLOTS];
  logic           pvld_q [PENDING_SLOTS];

  logic [31:0]     epoch_q;
  logic [CapW-1:0] cap_q;
  logic [NW-1:0]   nval_q;
  logic [CntW-1:0] c_hit_q, c_miss_q, c_comp_q, c_wait_q, c_evict_q;

  // request latch
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [31:0] hdl_q;
  logic        ok_q;
  logic [31:0] fep_q;

  // sequencer and scan results
  logic [1:0]      state_q;
  logic [IdxW-1:0] idx_q;
  logic            hit_q, vic_v_q, free_v_q, pm_v_q, pf_v_q;
  logic [EiW-1:0]  hit_i_q, vic_i_q, free_i_q;
  logic [RkW-1:0]  vic_r_q;
  logic [PiW-1:0]  pm_i_q, pf_i_q;
  logic [2:0]      st_q;
  logic [31:0]     plan_q;

  // output register
  logic            ov_q;
  logic [311:0]    odata_q;
  logic [2:0]      ouser_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // one scan step: the shared comparators
  logic [EiW-1:0] ei;
  logic [PiW-1:0] pi;
  logic           e_in, p_in, e_live, e_match, p_live, p_match;
  logic [31:0]    cmp_ep;
  always_comb begin
    ei      = idx_q[EiW-1:0];
    pi      = idx_q[PiW-1:0];
    e_in    = ({{(32-IdxW){1'b0}}, idx_q} < 32'(ENTRIES));
    p_in    = ({{(32-IdxW){1'b0}}, idx_q} < 32'(PENDING_SLOTS));
    cmp_ep  = (op_q == OpLookup) ? epoch_q : fep_q;
    e_live  = e_in && evld_q[ei];
    e_match = e_live && (ekey_q[ei] == key_q);
    p_live  = p_in && pvld_q[pi];
    p_match = p_live && (pkey_q[pi] == key_q) && (pep_q[pi] == cmp_ep);
  end

  // decide-cycle conditions
  logic [WideW-1:0] n_w, cap_w;
  logic             fill_go, evict_go, ins_go;
  logic [EiW-1:0]   slot;
  always_comb begin
    n_w      = WideW'(nval_q);
    cap_w    = WideW'(cap_q);
    fill_go  = (op_q == OpFill) && pm_v_q && ok_q && (fep_q == epoch_q) && (cap_q != '0);
    evict_go = fill_go && vic_v_q && (hit_q ? (n_w > cap_w) : (n_w >= cap_w));
    ins_go   = fill_go && !hit_q && (free_v_q || evict_go);
    if (free_v_q && !(evict_go && (vic_i_q < free_i_q))) slot = free_i_q;
    else slot = vic_i_q;
  end

  logic [CapW-1:0] cfg_sat;
  assign cfg_sat = (WideW'(cfg_wdata_i) > WideW'(ENTRIES)) ? CapW'(ENTRIES) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ov_q      <= 1'b0;
      epoch_q   <= '0;
      cap_q     <= CapRst;
      nval_q    <= '0;
      c_hit_q   <= '0;
      c_miss_q  <= '0;
      c_comp_q  <= '0;
      c_wait_q  <= '0;
      c_evict_q <= '0;
      idx_q     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        evld_q[i]  <= 1'b0;
        erank_q[i] <= '0;
      end
      for (int p = 0; p < PENDING_SLOTS; p++) pvld_q[p] <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_sat;
      if (ov_q && m_axis_tready) ov_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q     <= s_axis_tuser;
            key_q    <= s_axis_tdata[63:0];
            hdl_q    <= s_axis_tdata[95:64];
            ok_q     <= s_axis_tdata[96];
            fep_q    <= s_axis_tdata[128:97];
            idx_q    <= '0;
            hit_q    <= 1'b0;
            vic_v_q  <= 1'b0;
            free_v_q <= 1'b0;
            pm_v_q   <= 1'b0;
            pf_v_q   <= 1'b0;
            if ((s_axis_tuser == OpFill) || (s_axis_tuser == OpLookup && cap_q != '0))
              state_q <= S_SCAN;
            else
              state_q <= S_DEC;
          end
        end

        S_SCAN: begin
          if (e_match && !hit_q) begin
            hit_q   <= 1'b1;
            hit_i_q <= ei;
          end
          if (e_live && (!vic_v_q || erank_q[ei] > vic_r_q)) begin
            vic_v_q <= 1'b1;
            vic_i_q <= ei;
            vic_r_q <= erank_q[ei];
          end
          if (e_in && !evld_q[ei] && !free_v_q) begin
            free_v_q <= 1'b1;
            free_i_q <= ei;
          end
          if (p_match && !pm_v_q) begin
            pm_v_q <= 1'b1;
            pm_i_q <= pi;
          end
          if (p_in && !pvld_q[pi] && !pf_v_q) begin
            pf_v_q <= 1'b1;
            pf_i_q <= pi;
          end
          if ({{(32-IdxW){1'b0}}, idx_q} == 32'(Scan - 1)) state_q <= S_DEC;
          else idx_q <= idx_q + 1'b1;
        end

        S_DEC: begin
          plan_q  <= '0;
          st_q    <= StDiscarded;
          state_q <= S_OUT;
          case (op_q)
            OpLookup: begin
              if (cap_q == '0) begin
                c_miss_q <= c_miss_q + 1'b1;
                c_comp_q <= c_comp_q + 1'b1;
                st_q     <= StUncached;
              end else if (hit_q) begin
                // promote: everything more recent than the hit ages by one
                for (int i = 0; i < ENTRIES; i++)
                  if (evld_q[i] && erank_q[i] < erank_q[hit_i_q])
                    erank_q[i] <= erank_q[i] + 1'b1;
                erank_q[hit_i_q] <= '0;
                c_hit_q <= c_hit_q + 1'b1;
                st_q    <= StHit;
                plan_q  <= ehdl_q[hit_i_q];
              end else begin
                c_miss_q <= c_miss_q + 1'b1;
                if (pm_v_q) begin
                  c_wait_q <= c_wait_q + 1'b1;
                  st_q     <= StWait;
                end else if (pf_v_q) begin
                  pvld_q[pf_i_q] <= 1'b1;
                  pkey_q[pf_i_q] <= key_q;
                  pep_q[pf_i_q]  <= epoch_q;
                  c_comp_q <= c_comp_q + 1'b1;
                  st_q     <= StCompile;
                end else begin
                  st_q <= StPendFull;
                end
              end
            end
            OpFill: begin
              if (pm_v_q) pvld_q[pm_i_q] <= 1'b0;
              if (ins_go) begin
                for (int i = 0; i < ENTRIES; i++)
                  if (evld_q[i]) erank_q[i] <= erank_q[i] + 1'b1;
              end
              if (evict_go) begin
                evld_q[vic_i_q]  <= 1'b0;
                erank_q[vic_i_q] <= '0;
                c_evict_q <= c_evict_q + 1'b1;
              end
              if (ins_go) begin
                evld_q[slot]  <= 1'b1;
                ekey_q[slot]  <= key_q;
                ehdl_q[slot]  <= hdl_q;
                erank_q[slot] <= '0;
                st_q <= StStored;
              end
              if (evict_go && !ins_go) nval_q <= nval_q - 1'b1;
              else if (ins_go && !evict_go) nval_q <= nval_q + 1'b1;
            end
            OpClear: begin
              for (int i = 0; i < ENTRIES; i++) begin
                evld_q[i]  <= 1'b0;
                erank_q[i] <= '0;
              end
              nval_q  <= '0;
              epoch_q <= epoch_q + 1'b1;
              st_q    <= StCleared;
            end
            default: ;
          endcase
        end

        S_OUT: begin
          if (!ov_q || m_axis_tready) begin
            ov_q    <= 1'b1;
            ouser_q <= st_q;
            odata_q <= {3'b000, c_evict_q, c_wait_q, c_comp_q, c_miss_q, c_hit_q,
                        n_w[4:0], epoch_q, plan_q};
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
